### rtl/mf3_pkg.sv
// Shared constants, payload types and register codes for the 3x3 median filter.
// Self-contained; imported by every module of the block except mf3_line_ram.
`default_nettype none

package mf3_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_DIM     = 3;
    localparam int RST_WIDTH   = 640;
    localparam int RST_HEIGHT  = 480;

    localparam int PIX_W       = 8;
    localparam int CFG_WID_W   = 12;
    localparam int CFG_HGT_W   = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WEFF_W      = $clog2(MAX_WIDTH + 1);
    localparam int HEFF_W      = $clog2(MAX_HEIGHT + 1);
    // row counter runs one row past the frame while the last line drains
    localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
    localparam int CNT_W       = $clog2(MAX_WIDTH * MAX_HEIGHT);

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } mf3_reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             drain;
    } mf3_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } mf3_out_t;

    typedef struct packed {
        logic border;
        logic frame_end;
    } mf3_tag_t;

    // window entry 3*r+c: row r (0 = oldest line), column c (2 = newest)
    typedef logic [8:0][PIX_W-1:0] mf3_win_t;

endpackage

`default_nettype wire

### rtl/mf3_line_ram.sv
// Simple dual-port line store: one write port, one registered read port.
// Generic; no package dependency.
`default_nettype none

module mf3_line_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the old contents when the same entry is written in this cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/mf3_median_pipe.sv
// Three-stage median-of-nine network: sort rows, reduce columns, final median of three.
// Depends on mf3_pkg for the window, tag and result types.
`default_nettype none

module mf3_median_pipe
    import mf3_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire mf3_tag_t in_tag,
    input  wire mf3_win_t in_win,
    output logic          out_valid,
    output mf3_out_t      out_data
);

    function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic [2:0][PIX_W-1:0] lo_reg, mid_reg, hi_reg;
    logic [PIX_W-1:0]      ctr1_reg, ctr2_reg;
    mf3_tag_t              tag1_reg, tag2_reg;
    logic                  v1_reg, v2_reg, v3_reg;
    logic [PIX_W-1:0]      lo_max_reg, mid_med_reg, hi_min_reg;
    mf3_out_t              res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: sort each row of three
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                lo_reg[r]  <= min2(min2(in_win[3*r], in_win[3*r+1]), in_win[3*r+2]);
                mid_reg[r] <= med3(in_win[3*r], in_win[3*r+1], in_win[3*r+2]);
                hi_reg[r]  <= max2(max2(in_win[3*r], in_win[3*r+1]), in_win[3*r+2]);
            end
            ctr1_reg <= in_win[4];
            tag1_reg <= in_tag;
        end
    end

    // stage 2: largest low, median of middles, smallest high
    always_ff @(posedge aclk) begin
        if (en) begin
            lo_max_reg  <= max2(max2(lo_reg[0], lo_reg[1]), lo_reg[2]);
            mid_med_reg <= med3(mid_reg[0], mid_reg[1], mid_reg[2]);
            hi_min_reg  <= min2(min2(hi_reg[0], hi_reg[1]), hi_reg[2]);
            ctr2_reg    <= ctr1_reg;
            tag2_reg    <= tag1_reg;
        end
    end

    // stage 3: median of the three survivors, or the centre on a border
    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.pixel_out <= tag2_reg.border ? ctr2_reg
                                 : med3(lo_max_reg, mid_med_reg, hi_min_reg);
            res_reg.frame_end <= tag2_reg.frame_end;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = res_reg;

endmodule

`default_nettype wire

### rtl/mf3_out_fifo.sv
// Two-entry result queue that decouples the filter pipeline from the output handshake.
// Depends on mf3_pkg for the result type.
`default_nettype none

module mf3_out_fifo
    import mf3_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire mf3_out_t push_data,
    output logic          full,
    output logic          m_valid,
    input  wire logic     m_ready,
    output mf3_out_t      m_data
);

    mf3_out_t   slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = slot_reg[rd_ptr_reg];
    assign full    = (count_reg == 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/median_filter_3x3_unit.sv
// 3x3 median filter top level: stream position counters, line stores, window, result path.
// Depends on mf3_pkg, mf3_line_ram, mf3_median_pipe and mf3_out_fifo.
`default_nettype none

// Takes one 8-bit pixel per clock in raster order and gives one filtered pixel per clock
// once the pipe has filled: interior pixels become the median of their 3x3 neighbourhood,
// pixels on the four frame borders pass unchanged. A result belongs to the pixel one line
// plus one pixel earlier in the stream, so after the last pixel of a frame send width+1
// drain requests to flush it. Inside the block a request passes the line store read, the
// window load and three median stages in that order before it reaches the two-entry
// output queue; input is held off only while that queue is full. The line stores are
// single-write, single-read memories hit once each per pixel and need no clearing pass after
// reset. Writing frame_width or frame_height restarts the frame; do so only while idle.
module median_filter_3x3_unit
    import mf3_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [0:0]            cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire mf3_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output mf3_out_t                   m_data
);

    localparam int PROD_W = WEFF_W + HEFF_W;

    // configuration and frame geometry
    logic [CFG_WID_W-1:0] cfg_width_reg;
    logic [CFG_HGT_W-1:0] cfg_height_reg;
    logic [WEFF_W-1:0]    w_eff;
    logic [HEFF_W-1:0]    h_eff;
    logic [PROD_W-1:0]    prod;
    logic [CNT_W-1:0]     last_reg;

    // stream position
    logic [COL_W-1:0] in_column_reg, in_column_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;

    logic             en, accept;
    logic             have, frame_done, col_is_last, row_border, col_border;
    logic [ROW_W-1:0] crow, h_last;
    logic [PIX_W-1:0] pix;

    // request held during the line store read
    logic             valid_a_reg, have_a_reg, fwd_a_reg;
    logic [COL_W-1:0] col_a_reg;
    logic [PIX_W-1:0] pix_a_reg;
    mf3_tag_t         tag_a_reg;
    logic [PIX_W-1:0] fwd_upper_reg, fwd_middle_reg;
    logic [PIX_W-1:0] rd_upper, rd_middle, up_eff, mid_eff;

    mf3_win_t win_reg;
    logic     valid_b_reg;
    mf3_tag_t tag_b_reg;

    logic     pipe_valid, fifo_full;
    mf3_out_t pipe_data;

    // ---------------------------------------------------------------- geometry
    always_comb begin
        if (cfg_width_reg < CFG_WID_W'(MIN_DIM)) begin
            w_eff = WEFF_W'(MIN_DIM);
        end else if (32'(cfg_width_reg) > MAX_WIDTH) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEFF_W'(cfg_width_reg);
        end
        if (cfg_height_reg < CFG_HGT_W'(MIN_DIM)) begin
            h_eff = HEFF_W'(MIN_DIM);
        end else if (32'(cfg_height_reg) > MAX_HEIGHT) begin
            h_eff = HEFF_W'(MAX_HEIGHT);
        end else begin
            h_eff = HEFF_W'(cfg_height_reg);
        end
    end

    assign prod = PROD_W'(w_eff) * PROD_W'(h_eff);

    // settles long before the first result of a frame can be compared against it
    always_ff @(posedge aclk) begin
        last_reg <= CNT_W'(prod - PROD_W'(1));
    end

    // ---------------------------------------------------------------- input side
    assign en      = !fifo_full;
    assign s_ready = en;
    assign accept  = s_valid && en;
    assign pix     = s_data.drain ? '0 : s_data.pixel_in;

    assign col_is_last = (WEFF_W'(in_column_reg) == w_eff - WEFF_W'(1));
    assign have        = (in_column_reg != '0) ? (in_row_reg != '0)
                                               : (in_row_reg >= ROW_W'(2));
    // centre row: previous row, or two back when the centre is the last column
    assign crow        = (in_column_reg != '0) ? in_row_reg - ROW_W'(1)
                                               : in_row_reg - ROW_W'(2);
    assign h_last      = ROW_W'(h_eff) - ROW_W'(1);
    assign row_border  = (crow == '0) || (crow >= h_last);
    // centre column is the last one at column zero, the first one at column one
    assign col_border  = (in_column_reg == '0) || (in_column_reg == COL_W'(1));
    assign frame_done  = (out_count_reg >= last_reg);

    always_comb begin
        in_column_next = in_column_reg;
        in_row_next    = in_row_reg;
        out_count_next = out_count_reg;
        if (cfg_wr_en) begin
            in_column_next = '0;
            in_row_next    = '0;
            out_count_next = '0;
        end else if (accept) begin
            if (have && frame_done) begin
                in_column_next = '0;
                in_row_next    = '0;
                out_count_next = '0;
            end else begin
                if (col_is_last) begin
                    in_column_next = '0;
                    in_row_next    = in_row_reg + ROW_W'(1);
                end else begin
                    in_column_next = in_column_reg + COL_W'(1);
                end
                if (have) begin
                    out_count_next = out_count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= CFG_WID_W'(RST_WIDTH);
            cfg_height_reg <= CFG_HGT_W'(RST_HEIGHT);
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_count_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_FRAME_WIDTH:  cfg_width_reg  <= cfg_wr_data[CFG_WID_W-1:0];
                    REG_FRAME_HEIGHT: cfg_height_reg <= cfg_wr_data[CFG_HGT_W-1:0];
                    default: ;
                endcase
            end
            in_column_reg <= in_column_next;
            in_row_reg    <= in_row_next;
            out_count_reg <= out_count_next;
        end
    end

    // ---------------------------------------------------------------- line stores
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            fwd_a_reg   <= 1'b0;
        end else if (en) begin
            valid_a_reg <= accept;
            // back-to-back requests on the same column only happen at a frame restart
            fwd_a_reg   <= accept && valid_a_reg && (col_a_reg == in_column_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en && accept) begin
            col_a_reg           <= in_column_reg;
            pix_a_reg           <= pix;
            have_a_reg          <= have;
            tag_a_reg.border    <= row_border || col_border;
            tag_a_reg.frame_end <= frame_done;
        end
        // keep the last write in case the next read missed it
        if (en && valid_a_reg) begin
            fwd_upper_reg  <= mid_eff;
            fwd_middle_reg <= pix_a_reg;
        end
    end

    mf3_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (PIX_W)
    ) u_line_upper (
        .aclk    (aclk),
        .wr_en   (en && valid_a_reg),
        .wr_addr (col_a_reg),
        .wr_data (mid_eff),
        .rd_en   (accept),
        .rd_addr (in_column_reg),
        .rd_data (rd_upper)
    );

    mf3_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (PIX_W)
    ) u_line_middle (
        .aclk    (aclk),
        .wr_en   (en && valid_a_reg),
        .wr_addr (col_a_reg),
        .wr_data (pix_a_reg),
        .rd_en   (accept),
        .rd_addr (in_column_reg),
        .rd_data (rd_middle)
    );

    assign up_eff  = fwd_a_reg ? fwd_upper_reg  : rd_upper;
    assign mid_eff = fwd_a_reg ? fwd_middle_reg : rd_middle;

    // ---------------------------------------------------------------- window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= '0;
            valid_b_reg <= 1'b0;
        end else if (en) begin
            valid_b_reg <= valid_a_reg && have_a_reg;
            if (valid_a_reg) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[3*r]   <= win_reg[3*r+1];
                    win_reg[3*r+1] <= win_reg[3*r+2];
                end
                win_reg[2] <= up_eff;
                win_reg[5] <= mid_eff;
                win_reg[8] <= pix_a_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_b_reg <= tag_a_reg;
        end
    end

    // ---------------------------------------------------------------- result path
    mf3_median_pipe u_median (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid_b_reg),
        .in_tag    (tag_b_reg),
        .in_win    (win_reg),
        .out_valid (pipe_valid),
        .out_data  (pipe_data)
    );

    mf3_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (en && pipe_valid),
        .push_data (pipe_data),
        .full      (fifo_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // ---------------------------------------------------------------- assertions
    a_column_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        WEFF_W'(in_column_reg) < w_eff)
        else $error("column counter beyond frame width");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && have && frame_done && !cfg_wr_en)
        |=> (in_column_reg == '0) && (in_row_reg == '0) && (out_count_reg == '0))
        else $error("counters not cleared after last result of frame");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input held off with an empty output queue");

    a_forward_follows_request: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_a_reg |-> valid_a_reg && $past(valid_a_reg))
        else $error("line store bypass without a preceding write");

endmodule

`default_nettype wire

### verif/mf3_median_checker.sv
// Result checker for the 3x3 median filter: tracks geometry writes and accepted requests,
// predicts each filtered pixel and compares it with what the block gives.
// Depends on mf3_pkg for the payload types, register codes and size limits.

module mf3_median_checker
    import mf3_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [0:0]            cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire mf3_in_t               s_data,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire mf3_out_t              m_data,
    output int                         mismatch_count,
    output int                         results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 50;

    logic [PIX_W-1:0]     upper_row  [MAX_WIDTH];
    logic [PIX_W-1:0]     middle_row [MAX_WIDTH];
    mf3_win_t             win_regs;
    logic [CFG_WID_W-1:0] width_reg;
    logic [CFG_HGT_W-1:0] height_reg;
    int unsigned          next_col;
    int unsigned          next_row;
    int unsigned          results_in_frame;
    mf3_out_t             filtered_q [$];

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] median_of_nine(mf3_win_t v);
        logic [PIX_W-1:0] t;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8 - i; j++) begin
                if (v[j] > v[j+1]) begin
                    t = v[j];
                    v[j] = v[j+1];
                    v[j+1] = t;
                end
            end
        end
        return v[4];
    endfunction

    function automatic void restart_frame();
        next_col = 0;
        next_row = 0;
        results_in_frame = 0;
    endfunction

    task automatic predict_filtered_pixel(input mf3_in_t req);
        int unsigned w, h, col, crow, ccol;
        logic [PIX_W-1:0] pix;
        bit have, border;
        mf3_out_t res;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        pix = req.drain ? '0 : req.pixel_in;
        col = (next_col >= w) ? w - 1 : next_col;
        // slide left, load the new right-hand column from the line stores
        for (int r = 0; r < 3; r++) begin
            win_regs[3*r]   = win_regs[3*r+1];
            win_regs[3*r+1] = win_regs[3*r+2];
        end
        win_regs[2] = upper_row[col];
        win_regs[5] = middle_row[col];
        win_regs[8] = pix;
        upper_row[col]  = middle_row[col];
        middle_row[col] = pix;
        // window centre sits one line plus one pixel back in the stream
        have = 1'b0;
        crow = 0;
        ccol = 0;
        if (next_col >= 1) begin
            if (next_row >= 1) begin
                have = 1'b1;
                crow = next_row - 1;
                ccol = next_col - 1;
            end
        end else if (next_row >= 2) begin
            have = 1'b1;
            crow = next_row - 2;
            ccol = w - 1;
        end
        next_col++;
        if (next_col >= w) begin
            next_col = 0;
            next_row++;
        end
        if (have) begin
            border = (crow == 0) || (crow >= h - 1) || (ccol == 0) || (ccol >= w - 1);
            res.pixel_out = border ? win_regs[4] : median_of_nine(win_regs);
            res.frame_end = (results_in_frame >= w * h - 1);
            if (res.frame_end) begin
                restart_frame();
            end else begin
                results_in_frame++;
            end
            filtered_q.push_back(res);
        end
    endtask

    always @(posedge aclk) begin : watch_channels
        mf3_out_t want;
        if (!aresetn) begin
            width_reg = CFG_WID_W'(RST_WIDTH);
            height_reg = CFG_HGT_W'(RST_HEIGHT);
            for (int i = 0; i < MAX_WIDTH; i++) begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            win_regs = '0;
            restart_frame();
            filtered_q.delete();
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: result with none expected: pixel_out %0d frame_end %0d",
                                 $time, m_data.pixel_out, m_data.frame_end);
                    mismatch_count++;
                end else begin
                    want = filtered_q.pop_front();
                    if (want.pixel_out !== m_data.pixel_out) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("%0t: pixel_out expected %0d, got %0d",
                                     $time, want.pixel_out, m_data.pixel_out);
                        mismatch_count++;
                    end
                    if (want.frame_end !== m_data.frame_end) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("%0t: frame_end expected %0d, got %0d",
                                     $time, want.frame_end, m_data.frame_end);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                if (cfg_addr == REG_FRAME_WIDTH) begin
                    width_reg = cfg_wr_data[CFG_WID_W-1:0];
                end else begin
                    height_reg = cfg_wr_data[CFG_HGT_W-1:0];
                end
                restart_frame();
            end
            if (s_valid && s_ready) begin
                predict_filtered_pixel(s_data);
            end
        end
        results_owed = filtered_q.size();
    end

endmodule

### verif/testbench.sv
// Top of the median filter testbench: clock, reset, geometry writes and pixel stimulus.
// Depends on mf3_pkg, median_filter_3x3_unit and mf3_median_checker.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mf3_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1200;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [0:0]            cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    mf3_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    mf3_out_t              m_data;
    int                    mismatch_count;
    int                    results_owed;

    mf3_in_t               pixel_q [$];
    int unsigned           requests_queued = 0;
    int                    quiet_cycles = 0;

    median_filter_3x3_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    mf3_median_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic void queue_request(logic [PIX_W-1:0] pix, logic drain);
        mf3_in_t req;
        req.pixel_in = pix;
        req.drain = drain;
        pixel_q.push_back(req);
        requests_queued++;
    endfunction

    // style 0: black and white only, 1: values close together for ties, else uniform
    function automatic logic [PIX_W-1:0] pick_pixel(int unsigned style, logic [PIX_W-1:0] base);
        case (style)
            0: return $urandom_range(0, 1) ? '1 : '0;
            1: return base + PIX_W'($urandom_range(0, 3));
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // queue a frame and its drain requests; a non-zero cut abandons it after that many
    task automatic queue_frame(int unsigned w, int unsigned h, int unsigned cut);
        int unsigned total, style;
        logic [PIX_W-1:0] base;
        @(posedge aclk);
        total = w * h + w + 1;
        if (cut != 0 && cut < total) total = cut;
        style = $urandom_range(0, 3);
        base = PIX_W'($urandom);
        for (int unsigned k = 0; k < total; k++) begin
            if (k < w * h) begin
                queue_request(pick_pixel(style, base), $urandom_range(0, 39) == 0);
            end else begin
                queue_request(PIX_W'($urandom), $urandom_range(0, 4) != 0);
            end
        end
    endtask

    task automatic write_reg(mf3_reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // hold until every request is taken and every result is in, then let the pipe empty
    task automatic settle();
        bit busy;
        busy = 1'b1;
        while (busy) begin
            @(posedge aclk);
            busy = (pixel_q.size() != 0) || s_valid;
            @(negedge aclk);
            busy = busy || (results_owed != 0);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // request sender: bursts of random length with random gaps, some long unbroken runs
    initial begin : pixel_sender
        int burst_left, gap_left;
        bit took;
        s_valid = 1'b0;
        s_data = '0;
        burst_left = 0;
        gap_left = 0;
        forever begin
            @(posedge aclk);
            took = s_valid && s_ready;
            @(negedge aclk);
            if (!s_valid || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    s_data <= pixel_q.pop_front();
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 5) == 0) begin
                            burst_left = $urandom_range(100, 400);
                            gap_left = 0;
                        end else begin
                            burst_left = $urandom_range(1, 40);
                            gap_left = $urandom_range(0, 12);
                        end
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    initial begin : result_sink
        int unsigned mode, len, tick;
        m_ready = 1'b0;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 4);
            len = $urandom_range(8, 120);
            repeat (len) begin
                @(negedge aclk);
                tick++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    3: m_ready <= ($urandom_range(0, 15) != 0);
                    default: m_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** median_filter_3x3_unit: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        logic [PIX_W-1:0] corner_pix [9];
        logic [PIX_W-1:0] ramp_pix [9];
        int unsigned r, wval, hval, ew, eh, nframes, cut, start_count;
        logic [CFG_DATA_W-1:0] wdata, hdata;

        corner_pix = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd255, 8'd0};
        ramp_pix = '{8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90};
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_FRAME_WIDTH;
        cfg_wr_data = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // reset geometry: one line and a few pixels, enough for the first results to show
        queue_frame(RST_WIDTH, RST_HEIGHT, RST_WIDTH + 24);
        settle();

        // smallest frame, both registers below range
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
        @(posedge aclk);
        for (int k = 0; k < 9; k++) queue_request(corner_pix[k], 1'b0);
        // a real pixel where a drain is due, then drains carrying junk
        queue_request(8'hAA, 1'b0);
        repeat (3) queue_request(8'hFF, 1'b1);
        // drain in the middle of a frame lands as a zero in the centre
        for (int k = 0; k < 9; k++) queue_request(k == 4 ? 8'h77 : ramp_pix[k], k == 4);
        repeat (4) queue_request(PIX_W'($urandom), 1'b1);
        settle();

        start_count = requests_queued;
        while (requests_queued - start_count < RANDOM_ITEMS) begin
            r = $urandom_range(0, 19);
            wval = (r == 0) ? $urandom_range(0, 2) :
                   (r < 15) ? $urandom_range(3, 10) : $urandom_range(11, 40);
            hval = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            ew = (wval < MIN_DIM) ? MIN_DIM : wval;
            eh = (hval < MIN_DIM) ? MIN_DIM : hval;
            // bit above the width field must be dropped
            wdata = {1'($urandom_range(0, 1)), CFG_WID_W'(wval)};
            hdata = CFG_DATA_W'(hval);
            if ($urandom_range(0, 1)) begin
                write_reg(REG_FRAME_WIDTH, wdata);
                write_reg(REG_FRAME_HEIGHT, hdata);
            end else begin
                write_reg(REG_FRAME_HEIGHT, hdata);
                write_reg(REG_FRAME_WIDTH, wdata);
            end
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++) begin
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, ew * eh + ew) : 0;
                queue_frame(ew, eh, cut);
                if (cut != 0) break;
            end
            settle();
        end

        if (mismatch_count == 0 && results_owed == 0) begin
            $display("** median_filter_3x3_unit: PASSED **");
        end else begin
            $display("** median_filter_3x3_unit: FAILED **");
        end
        $finish;
    end

endmodule
